// File: design/integer_divide_modulus_unit_defines.svh
// Assertion macros for the divide / modulus unit
`ifndef INTEGER_DIVIDE_MODULUS_UNIT_DEFINES_SVH
`define INTEGER_DIVIDE_MODULUS_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IDMU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("idmu check failed");

// next-cycle implication, checked out of reset
`define IDMU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("idmu check failed");

`endif

// File: design/idmu_pkg.sv
package idmu_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   localparam logic [1:0] OP_UDIV = 2'd0;
   localparam logic [1:0] OP_SDIV = 2'd1;
   localparam logic [1:0] OP_UREM = 2'd2;
   localparam logic [1:0] OP_SREM = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

endpackage

// File: design/idmu_core.sv
module idmu_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [idmu_pkg::DATA_WIDTH-1:0]     dividend,
   input  logic [idmu_pkg::DATA_WIDTH-1:0]     divisor,
   input  logic                                take,
   output idmu_pkg::core_status_type           status,
   output logic [idmu_pkg::DATA_WIDTH-1:0]     quotient,
   output logic [idmu_pkg::DATA_WIDTH-1:0]     remainder
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int W = idmu_pkg::DATA_WIDTH;
   localparam logic [idmu_pkg::CNT_WIDTH-1:0] LAST_STEP = idmu_pkg::CNT_WIDTH'(W - 1);
   localparam logic [idmu_pkg::CNT_WIDTH-1:0] ONE_STEP  = idmu_pkg::CNT_WIDTH'(1);

   logic [1:0]                      state_ff, state_in;
   logic [idmu_pkg::CNT_WIDTH-1:0]  count_ff, count_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W-1:0]                    div_ff, div_in;

   logic [W:0]   shifted;
   logic [W+1:0] diff;
   logic         fits;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = ~diff[W+1];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               count_in = LAST_STEP;
               rem_in   = '0;
               quo_in   = dividend;
               div_in   = divisor;
            end
         end
         ST_RUN: begin
            // shift in one dividend bit, subtract where it fits
            rem_in   = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_in   = {quo_ff[W-2:0], fits};
            count_in = count_ff - ONE_STEP;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// File: design/integer_divide_modulus_unit.sv
// Operation: the req beat starts 32 shift-subtract steps of the single subtractor
// in idmu_core; the sign is fixed as the result is registered into the output.
// No new item is taken while idmu_core is busy; req_ready returns once the result
// moves to the output register, so a new item may start while that result waits.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
`include "integer_divide_modulus_unit_defines.svh"

module integer_divide_modulus_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [idmu_pkg::DATA_WIDTH-1:0]     req_dividend,
   input  logic [idmu_pkg::DATA_WIDTH-1:0]     req_divisor,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [idmu_pkg::DATA_WIDTH-1:0]     rsp_result,
   output logic                                rsp_divide_by_zero
);

   localparam int W = idmu_pkg::DATA_WIDTH;

   idmu_pkg::core_status_type status;

   logic         accept;
   logic         take;
   logic         is_signed;
   logic [W-1:0] mag_dividend;
   logic [W-1:0] mag_divisor;
   logic [W-1:0] quotient;
   logic [W-1:0] remainder;
   logic [W-1:0] fixed_quo;
   logic [W-1:0] fixed_rem;

   logic         is_mod_ff;
   logic         neg_q_ff;
   logic         neg_r_ff;
   logic         zero_ff;
   logic [W-1:0] dividend_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_result_ff, rsp_result_in;
   logic         rsp_dbz_ff, rsp_dbz_in;

   assign req_ready = ~status.busy;
   assign accept    = req_valid & req_ready;
   assign take      = status.done & (~rsp_valid_ff | rsp_ready);

   assign is_signed    = (req_opcode == idmu_pkg::OP_SDIV) || (req_opcode == idmu_pkg::OP_SREM);
   assign mag_dividend = (is_signed && req_dividend[W-1]) ? (~req_dividend + W'(1)) : req_dividend;
   assign mag_divisor  = (is_signed && req_divisor[W-1]) ? (~req_divisor + W'(1)) : req_divisor;

   idmu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (mag_dividend),
      .divisor   (mag_divisor),
      .take      (take),
      .status    (status),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         is_mod_ff   <= (req_opcode == idmu_pkg::OP_UREM) || (req_opcode == idmu_pkg::OP_SREM);
         neg_q_ff    <= is_signed & (req_dividend[W-1] ^ req_divisor[W-1]);
         neg_r_ff    <= is_signed & req_dividend[W-1];
         zero_ff     <= (req_divisor == '0);
         dividend_ff <= req_dividend;
      end
   end

   assign fixed_quo = neg_q_ff ? (~quotient + W'(1)) : quotient;
   assign fixed_rem = neg_r_ff ? (~remainder + W'(1)) : remainder;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_dbz_in    = rsp_dbz_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_dbz_in   = zero_ff;
         priority if (zero_ff) begin
            rsp_result_in = is_mod_ff ? dividend_ff : '1;
         end else if (is_mod_ff) begin
            rsp_result_in = fixed_rem;
         end else begin
            rsp_result_in = fixed_quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
      rsp_dbz_ff    <= rsp_dbz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

   `IDMU_ASSERT_NEXT(a_accept_starts_core, accept, status.busy)
   `IDMU_ASSERT_NEXT(a_take_fills_output, take, rsp_valid_ff)
   `IDMU_ASSERT_SAME(a_done_is_busy, status.done, status.busy)

endmodule
